// ===== rtl/regression_intercept_accumulator_assert.svh =====
// Assertion macros shared by the regression intercept accumulator RTL.
// Each macro takes a label, a clock, a reset, an antecedent and a consequent.
`ifndef REGRESSION_INTERCEPT_ACCUMULATOR_ASSERT_SVH
`define REGRESSION_INTERCEPT_ACCUMULATOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
// The consequent must hold in the same cycle as the antecedent.
`define RIA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed in %m");
// The consequent must hold in the cycle after the antecedent.
`define RIA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed in %m");
`else
`define RIA_ASSERT_NOW(label, clk, rst, ante, cons)
`define RIA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/ria_pkg.sv =====
package ria_pkg;

   // Default sample width and log2 of the sample capacity.
   localparam int RIA_SAMPLE_WIDTH     = 24;
   localparam int RIA_MAX_SAMPLES_LOG2 = 16;

   // The intercept is reported as a 32-bit signed value.
   localparam int RESULT_W = 32;
   localparam logic [RESULT_W-1:0] RESULT_POS_LIMIT = 32'h7FFF_FFFF;
   localparam logic [RESULT_W-1:0] RESULT_NEG_LIMIT = 32'h8000_0000;

   typedef enum logic [1:0] {
      CMD_CLEAR = 2'd0,
      CMD_ADD   = 2'd1,
      CMD_READ  = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_SQ,
      ST_MUL_XP,
      ST_ACC_XP,
      ST_SOLVE
   } ria_state_type;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_DEN_A,
      PH_DEN_B,
      PH_NUM_A,
      PH_NUM_B,
      PH_ABS,
      PH_DIV,
      PH_DONE
   } sol_phase_type;

   typedef struct packed {
      logic clear;
      logic drop;
      logic capture;
      logic mul_sq;
      logic mul_xp;
      logic acc_xp;
   } accum_ctl_type;

   typedef struct packed {
      logic full;
      logic dropped;
   } accum_stat_type;

endpackage

// ===== rtl/regression_intercept_accumulator.sv =====
// Channel      Direction  Handshake          Contents
// request      in         start / busy       req_command, req_dependent_sample,
//                                            req_independent_sample, req_pair_present
// response     out        rsp_valid strobe   rsp_intercept_value, rsp_result_null,
//                                            rsp_result_saturated, rsp_samples_dropped
//
// A transaction is taken at a rising edge with start high and busy low.
// Clear, an ignored add, a dropped add and the unused command code leave busy low.
// An accepted add steps through ST_MUL_SQ, ST_MUL_XP and ST_ACC_XP; a new transaction
// can be taken again in ST_ACC_XP. A read keeps busy high while the solver's shared
// adder forms the products by shift and add and, unless the result is null, runs the
// restoring division; rsp_valid pulses in the first cycle in which busy is low again.
// Reset is synchronous and clears all sums and the dropped flag. The response cannot be stalled.

module regression_intercept_accumulator import ria_pkg::*; #(
   parameter int SAMPLE_WIDTH     = RIA_SAMPLE_WIDTH,
   parameter int MAX_SAMPLES_LOG2 = RIA_MAX_SAMPLES_LOG2
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic        [1:0]              req_command,
   input  logic signed [SAMPLE_WIDTH-1:0] req_dependent_sample,
   input  logic signed [SAMPLE_WIDTH-1:0] req_independent_sample,
   input  logic                           req_pair_present,
   output logic                           rsp_valid,
   output logic signed [RESULT_W-1:0]     rsp_intercept_value,
   output logic                           rsp_result_null,
   output logic                           rsp_result_saturated,
   output logic                           rsp_samples_dropped
);

   localparam int CNT_W = MAX_SAMPLES_LOG2 + 1;
   localparam int SUM_W = SAMPLE_WIDTH + MAX_SAMPLES_LOG2;
   localparam int SQ_W  = 2 * SAMPLE_WIDTH + MAX_SAMPLES_LOG2 - 1;
   localparam int XP_W  = 2 * SAMPLE_WIDTH + MAX_SAMPLES_LOG2;

   ria_state_type state_ff, state_in, accept_state;
   accum_ctl_type ctl;
   accum_stat_type stat;
   logic accept;
   logic sol_start, sol_finish;

   logic        [CNT_W-1:0]    count;
   logic signed [SUM_W-1:0]    sum_x, sum_y;
   logic        [SQ_W-1:0]     sum_xx;
   logic signed [XP_W-1:0]     sum_xy;
   logic        [RESULT_W-1:0] sol_value;

   // A transaction can be accepted when idle, and also in the last cycle of an add,
   // where only the cross-product sum is still being updated. The solver loads
   // that sum much later, so a read taken in that cycle still sees it final.
   assign busy   = !((state_ff == ST_IDLE) || (state_ff == ST_ACC_XP));
   assign accept = start && !busy;

   always_comb begin
      ctl          = '0;
      sol_start    = 1'b0;
      accept_state = ST_IDLE;
      state_in     = state_ff;

      if (accept) begin
         unique case (req_command)
            CMD_CLEAR: begin
               ctl.clear = 1'b1;
            end
            CMD_ADD: begin
               // A pair with a missing value changes nothing. A pair beyond
               // capacity only raises the dropped flag.
               if (req_pair_present) begin
                  if (stat.full) begin
                     ctl.drop = 1'b1;
                  end else begin
                     ctl.capture  = 1'b1;
                     accept_state = ST_MUL_SQ;
                  end
               end
            end
            CMD_READ: begin
               sol_start    = 1'b1;
               accept_state = ST_SOLVE;
            end
            default: begin
               // The unused command code is taken and ignored.
            end
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            state_in = accept_state;
         end
         ST_MUL_SQ: begin
            ctl.mul_sq = 1'b1;
            state_in   = ST_MUL_XP;
         end
         ST_MUL_XP: begin
            ctl.mul_xp = 1'b1;
            state_in   = ST_ACC_XP;
         end
         ST_ACC_XP: begin
            ctl.acc_xp = 1'b1;
            state_in   = accept_state;
         end
         ST_SOLVE: begin
            if (sol_finish) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   ria_accum #(
      .SAMPLE_WIDTH     (SAMPLE_WIDTH),
      .MAX_SAMPLES_LOG2 (MAX_SAMPLES_LOG2)
   ) u_accum (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .sample_x (req_independent_sample),
      .sample_y (req_dependent_sample),
      .stat     (stat),
      .count    (count),
      .sum_x    (sum_x),
      .sum_y    (sum_y),
      .sum_xx   (sum_xx),
      .sum_xy   (sum_xy)
   );

   ria_solver #(
      .SAMPLE_WIDTH     (SAMPLE_WIDTH),
      .MAX_SAMPLES_LOG2 (MAX_SAMPLES_LOG2)
   ) u_solver (
      .clock     (clock),
      .reset     (reset),
      .start     (sol_start),
      .count     (count),
      .sum_x     (sum_x),
      .sum_y     (sum_y),
      .sum_xx    (sum_xx),
      .sum_xy    (sum_xy),
      .finish    (sol_finish),
      .rsp_valid (rsp_valid),
      .rsp_value (sol_value),
      .rsp_null  (rsp_result_null),
      .rsp_sat   (rsp_result_saturated)
   );

   assign rsp_intercept_value = sol_value;
   // The dropped flag cannot change while a read is in flight.
   assign rsp_samples_dropped = stat.dropped;

   // The response strobe only follows the end of a read, in the cycle after it.
   `RIA_ASSERT_NOW(a_rsp_idle, clock, reset, rsp_valid, state_ff == ST_IDLE)
   `RIA_ASSERT_NEXT(a_rsp_follows, clock, reset, state_ff == ST_SOLVE && sol_finish, rsp_valid)

endmodule

// ===== rtl/ria_accum.sv =====
`include "regression_intercept_accumulator_assert.svh"

module ria_accum import ria_pkg::*; #(
   parameter int SAMPLE_WIDTH     = RIA_SAMPLE_WIDTH,
   parameter int MAX_SAMPLES_LOG2 = RIA_MAX_SAMPLES_LOG2,
   localparam int CNT_W  = MAX_SAMPLES_LOG2 + 1,
   localparam int SUM_W  = SAMPLE_WIDTH + MAX_SAMPLES_LOG2,
   localparam int SQ_W   = 2 * SAMPLE_WIDTH + MAX_SAMPLES_LOG2 - 1,
   localparam int XP_W   = 2 * SAMPLE_WIDTH + MAX_SAMPLES_LOG2,
   localparam int PROD_W = 2 * SAMPLE_WIDTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  accum_ctl_type                  ctl,
   input  logic signed [SAMPLE_WIDTH-1:0] sample_x,
   input  logic signed [SAMPLE_WIDTH-1:0] sample_y,
   output accum_stat_type                 stat,
   output logic        [CNT_W-1:0]        count,
   output logic signed [SUM_W-1:0]        sum_x,
   output logic signed [SUM_W-1:0]        sum_y,
   output logic        [SQ_W-1:0]         sum_xx,
   output logic signed [XP_W-1:0]         sum_xy
);

   logic        [CNT_W-1:0]        count_ff, count_in;
   logic signed [SUM_W-1:0]        sx_ff, sx_in;
   logic signed [SUM_W-1:0]        sy_ff, sy_in;
   logic        [SQ_W-1:0]         sxx_ff, sxx_in;
   logic signed [XP_W-1:0]         sxy_ff, sxy_in;
   logic                           dropped_ff, dropped_in;
   logic signed [SAMPLE_WIDTH-1:0] x_ff, y_ff;
   logic signed [SAMPLE_WIDTH-1:0] mul_b;
   logic signed [PROD_W-1:0]       prod_ff, prod_in;

   // One multiplier serves both products: x*x first, then x*y.
   assign mul_b   = ctl.mul_xp ? y_ff : x_ff;
   assign prod_in = x_ff * mul_b;

   always_comb begin
      count_in   = count_ff;
      sx_in      = sx_ff;
      sy_in      = sy_ff;
      sxx_in     = sxx_ff;
      sxy_in     = sxy_ff;
      dropped_in = dropped_ff;
      if (ctl.drop) begin
         dropped_in = 1'b1;
      end
      if (ctl.capture) begin
         count_in = count_ff + CNT_W'(1);
         sx_in    = sx_ff + SUM_W'(sample_x);
         sy_in    = sy_ff + SUM_W'(sample_y);
      end
      if (ctl.mul_xp) begin
         sxx_in = sxx_ff + SQ_W'(prod_ff[PROD_W-2:0]);
      end
      if (ctl.acc_xp) begin
         sxy_in = sxy_ff + XP_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         count_ff   <= '0;
         sx_ff      <= '0;
         sy_ff      <= '0;
         sxx_ff     <= '0;
         sxy_ff     <= '0;
         dropped_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         sx_ff      <= sx_in;
         sy_ff      <= sy_in;
         sxx_ff     <= sxx_in;
         sxy_ff     <= sxy_in;
         dropped_ff <= dropped_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         x_ff <= sample_x;
         y_ff <= sample_y;
      end
      prod_ff <= prod_in;
   end

   assign stat.full    = count_ff[MAX_SAMPLES_LOG2];
   assign stat.dropped = dropped_ff;
   assign count        = count_ff;
   assign sum_x        = sx_ff;
   assign sum_y        = sy_ff;
   assign sum_xx       = sxx_ff;
   assign sum_xy       = sxy_ff;

   // The count stops exactly at capacity.
   `RIA_ASSERT_NOW(a_count_cap, clock, reset, count_ff[MAX_SAMPLES_LOG2], count_ff[MAX_SAMPLES_LOG2-1:0] == '0)

endmodule

// ===== rtl/ria_solver.sv =====
`include "regression_intercept_accumulator_assert.svh"

module ria_solver import ria_pkg::*; #(
   parameter int SAMPLE_WIDTH     = RIA_SAMPLE_WIDTH,
   parameter int MAX_SAMPLES_LOG2 = RIA_MAX_SAMPLES_LOG2,
   localparam int CNT_W  = MAX_SAMPLES_LOG2 + 1,
   localparam int SUM_W  = SAMPLE_WIDTH + MAX_SAMPLES_LOG2,
   localparam int SQ_W   = 2 * SAMPLE_WIDTH + MAX_SAMPLES_LOG2 - 1,
   localparam int XP_W   = 2 * SAMPLE_WIDTH + MAX_SAMPLES_LOG2,
   localparam int NUM_W  = 3 * SAMPLE_WIDTH + 2 * MAX_SAMPLES_LOG2,
   localparam int STEP_W = $clog2(NUM_W)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic        [CNT_W-1:0]    count,
   input  logic signed [SUM_W-1:0]    sum_x,
   input  logic signed [SUM_W-1:0]    sum_y,
   input  logic        [SQ_W-1:0]     sum_xx,
   input  logic signed [XP_W-1:0]     sum_xy,
   output logic                       finish,
   output logic                       rsp_valid,
   output logic        [RESULT_W-1:0] rsp_value,
   output logic                       rsp_null,
   output logic                       rsp_sat
);

   sol_phase_type       phase_ff, phase_in;
   logic                valid_ff, valid_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [NUM_W-1:0]    acc_ff, acc_in;
   logic [SUM_W-1:0]    mplier_ff, mplier_in;
   logic [NUM_W-1:0]    mcand_ff, mcand_in;
   logic                sub_ff, sub_in;
   logic [NUM_W-1:0]    den_ff, den_in;
   logic [NUM_W-1:0]    quo_ff, quo_in;
   logic                neg_ff, neg_in;
   logic                null_ff, null_in;
   logic                sat_ff, sat_in;
   logic [RESULT_W-1:0] value_ff, value_in;

   logic [SUM_W-1:0]    sx_mag, sy_mag;
   logic [XP_W-1:0]     sxy_mag;
   logic [NUM_W-1:0]    op_a, op_b, au_sum;
   logic                op_sub;
   logic [NUM_W-1:0]    acc_step, rem_shift;
   logic                last, qbit, over;
   logic [RESULT_W-1:0] limit, mag;

   assign sx_mag  = sum_x[SUM_W-1]  ? SUM_W'(-sum_x)  : SUM_W'(sum_x);
   assign sy_mag  = sum_y[SUM_W-1]  ? SUM_W'(-sum_y)  : SUM_W'(sum_y);
   assign sxy_mag = sum_xy[XP_W-1]  ? XP_W'(-sum_xy)  : XP_W'(sum_xy);

   assign rem_shift = {acc_ff[NUM_W-2:0], quo_ff[NUM_W-1]};

   // The shared wide adder/subtractor. Products are built by shift and add,
   // the magnitude is taken by a subtract from zero and the quotient comes from
   // restoring division, all through this one unit.
   always_comb begin
      unique case (phase_ff)
         PH_DIV: begin
            op_a   = rem_shift;
            op_b   = den_ff;
            op_sub = 1'b1;
         end
         PH_ABS: begin
            op_a   = '0;
            op_b   = acc_ff;
            op_sub = acc_ff[NUM_W-1];
         end
         default: begin
            op_a   = acc_ff;
            op_b   = mcand_ff;
            op_sub = sub_ff;
         end
      endcase
   end

   assign au_sum   = op_a + (op_sub ? ~op_b : op_b) + NUM_W'(op_sub);
   assign acc_step = mplier_ff[0] ? au_sum : acc_ff;
   assign last     = (step_ff == '0);
   assign qbit     = ~au_sum[NUM_W-1];

   assign limit = neg_ff ? RESULT_NEG_LIMIT : RESULT_POS_LIMIT;
   assign over  = quo_ff > NUM_W'(limit);
   assign mag   = over ? limit : quo_ff[RESULT_W-1:0];

   always_comb begin
      phase_in  = phase_ff;
      valid_in  = 1'b0;
      step_in   = step_ff;
      acc_in    = acc_ff;
      mplier_in = mplier_ff;
      mcand_in  = mcand_ff;
      sub_in    = sub_ff;
      den_in    = den_ff;
      quo_in    = quo_ff;
      neg_in    = neg_ff;
      null_in   = null_ff;
      sat_in    = sat_ff;
      value_in  = value_ff;
      unique case (phase_ff)
         PH_IDLE: begin
            if (start) begin
               acc_in    = '0;
               mplier_in = SUM_W'(count);
               mcand_in  = NUM_W'(sum_xx);
               sub_in    = 1'b0;
               step_in   = STEP_W'(SUM_W - 1);
               phase_in  = PH_DEN_A;
            end
         end
         PH_DEN_A, PH_DEN_B, PH_NUM_A, PH_NUM_B: begin
            acc_in    = acc_step;
            mplier_in = mplier_ff >> 1;
            mcand_in  = mcand_ff << 1;
            step_in   = step_ff - STEP_W'(1);
            if (last) begin
               step_in = STEP_W'(SUM_W - 1);
               unique case (phase_ff)
                  PH_DEN_A: begin
                     mplier_in = sx_mag;
                     mcand_in  = NUM_W'(sx_mag);
                     sub_in    = 1'b1;
                     phase_in  = PH_DEN_B;
                  end
                  PH_DEN_B: begin
                     den_in    = acc_step;
                     acc_in    = '0;
                     mplier_in = sy_mag;
                     mcand_in  = NUM_W'(sum_xx);
                     sub_in    = sum_y[SUM_W-1];
                     phase_in  = PH_NUM_A;
                  end
                  PH_NUM_A: begin
                     mplier_in = sx_mag;
                     mcand_in  = NUM_W'(sxy_mag);
                     sub_in    = ~(sum_x[SUM_W-1] ^ sum_xy[XP_W-1]);
                     phase_in  = PH_NUM_B;
                  end
                  default: begin
                     phase_in = PH_ABS;
                  end
               endcase
            end
         end
         PH_ABS: begin
            quo_in   = au_sum;
            neg_in   = acc_ff[NUM_W-1];
            null_in  = (den_ff == '0);
            acc_in   = '0;
            step_in  = STEP_W'(NUM_W - 1);
            phase_in = (den_ff == '0) ? PH_DONE : PH_DIV;
         end
         PH_DIV: begin
            acc_in  = qbit ? au_sum : rem_shift;
            quo_in  = {quo_ff[NUM_W-2:0], qbit};
            step_in = step_ff - STEP_W'(1);
            if (last) begin
               phase_in = PH_DONE;
            end
         end
         PH_DONE: begin
            valid_in = 1'b1;
            phase_in = PH_IDLE;
            if (null_ff) begin
               value_in = '0;
               sat_in   = 1'b0;
            end else begin
               value_in = neg_ff ? -mag : mag;
               sat_in   = over;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         valid_ff <= 1'b0;
         step_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         valid_ff <= valid_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      mplier_ff <= mplier_in;
      mcand_ff  <= mcand_in;
      sub_ff    <= sub_in;
      den_ff    <= den_in;
      quo_ff    <= quo_in;
      neg_ff    <= neg_in;
      null_ff   <= null_in;
      sat_ff    <= sat_in;
      value_ff  <= value_in;
   end

   assign finish    = (phase_ff == PH_DONE);
   assign rsp_valid = valid_ff;
   assign rsp_value = value_ff;
   assign rsp_null  = null_ff;
   assign rsp_sat   = sat_ff;

   // Division only runs with a nonzero divisor, and the partial remainder
   // stays below it.
   `RIA_ASSERT_NOW(a_div_den, clock, reset, phase_ff == PH_DIV, den_ff != '0)
   `RIA_ASSERT_NOW(a_div_rem, clock, reset, phase_ff == PH_DIV, acc_ff < den_ff)
   `RIA_ASSERT_NOW(a_null_zero, clock, reset, valid_ff && null_ff, value_ff == '0 && !sat_ff)

endmodule
